// ===== sv/prs_pkg.sv =====
package prs_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_PARTICLES = 64;
   localparam int DEF_DIM           = 4;
   localparam int DEF_ELEM_BITS     = 16;

   // Fixed field and datapath widths
   localparam int WEIGHT_W  = 16;
   localparam int RAND_W    = 16;
   localparam int ELEM_W    = 16;
   localparam int NUM_ELEMS = 4;
   localparam int INDEX_W   = 6;
   localparam int NEW_W_W   = 17;
   localparam int CUM_W     = 22;              // running weight sum
   localparam int COUNT_W   = 7;               // particle count, up to 64
   localparam int SLOT_W    = INDEX_W + RAND_W; // i*65536 + r
   localparam int RHS_W     = SLOT_W + CUM_W;  // slot term times total
   localparam int LHS_W     = CUM_W + COUNT_W; // cum times N
   localparam int CMP_W     = LHS_W + RAND_W;  // cum*N*65536

   typedef enum logic [1:0] {
      M_SYSTEMATIC  = 2'd0,
      M_STRATIFIED  = 2'd1,
      M_MULTINOMIAL = 2'd2,
      M_RESIDUAL    = 2'd3
   } method_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_ZERO_WEIGHT = 2'd1,
      ST_NO_METHOD   = 2'd2,
      ST_OVERFLOW    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_RHS,
      S_LHS,
      S_CMP,
      S_OUT,
      S_ERR
   } state_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0]      weight;
      logic [RAND_W-1:0]        rand_frac;
      logic signed [ELEM_W-1:0] elem_a;
      logic signed [ELEM_W-1:0] elem_b;
      logic signed [ELEM_W-1:0] elem_c;
      logic signed [ELEM_W-1:0] elem_d;
      logic                     last;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [INDEX_W-1:0]       source_index;
      logic signed [ELEM_W-1:0] out_a;
      logic signed [ELEM_W-1:0] out_b;
      logic signed [ELEM_W-1:0] out_c;
      logic signed [ELEM_W-1:0] out_d;
      logic [NEW_W_W-1:0]       new_weight;
      logic                     final_res;
   } rsp_type;

   // floor(65536 / N), indexed by N-1
   localparam logic [NEW_W_W-1:0] NEW_WEIGHT_TABLE [64] = '{
      17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362, 17'd8192,
      17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369, 17'd4096,
      17'd3855,  17'd3640,  17'd3449,  17'd3276,  17'd3120,  17'd2978,  17'd2849, 17'd2730,
      17'd2621,  17'd2520,  17'd2427,  17'd2340,  17'd2259,  17'd2184,  17'd2114, 17'd2048,
      17'd1985,  17'd1927,  17'd1872,  17'd1820,  17'd1771,  17'd1724,  17'd1680, 17'd1638,
      17'd1598,  17'd1560,  17'd1524,  17'd1489,  17'd1456,  17'd1424,  17'd1394, 17'd1365,
      17'd1337,  17'd1310,  17'd1285,  17'd1260,  17'd1236,  17'd1213,  17'd1191, 17'd1170,
      17'd1149,  17'd1129,  17'd1110,  17'd1092,  17'd1074,  17'd1057,  17'd1040, 17'd1024
   };

endpackage

// ===== sv/particle_resampler.sv =====
// Particle resampler.
// Request channel (req_valid / req_stall / req_data): one particle per request,
// one per cycle while loading. The request with last set closes the run and
// starts resampling; req_stall stays high until the run's final result has
// been loaded into the output register.
// Result channel (rsp_valid / rsp_stall / rsp_data): N results per run, one
// per output slot, final_res set on the last one. An error (too many
// particles, residual method, zero total weight) gives one result instead.
// Search: each slot passes through RHS, then LHS and CMP, repeated once for
// each of the k cumulative sums stepped over by the search (one memory read,
// one compare and, outside multinomial mode, one multiply per step), then
// OUT. In systematic and stratified modes the search index only moves
// forward, so k summed over a run is at most N-1; multinomial restarts the
// search at particle 0 for every slot. A START state precedes the first slot.
// A stalled result holds in the output register; the sequencer waits for it.
// Reset (synchronous) empties the run, empties the result register and sets
// the method register to systematic. csr_wr_en writes the method register.
module particle_resampler #(
   parameter int MAX_PARTICLES = prs_pkg::DEF_MAX_PARTICLES,
   parameter int DIM           = prs_pkg::DEF_DIM,
   parameter int ELEM_BITS     = prs_pkg::DEF_ELEM_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  prs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output prs_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data
);

   localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam int PART_W = DIM * ELEM_BITS;

   // Control registers
   prs_pkg::state_type  state_ff, state_in;
   prs_pkg::method_type method_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [prs_pkg::CUM_W-1:0] sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Run and search registers
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [prs_pkg::CUM_W-1:0] total_ff, total_in;
   prs_pkg::status_type       err_ff, err_in;
   logic [IDX_W-1:0]          i_ff, i_in;
   logic [IDX_W-1:0]          j_ff, j_in;
   logic [prs_pkg::RHS_W-1:0] rhs_ff, rhs_in;
   logic [prs_pkg::LHS_W-1:0] lhs_ff, lhs_in;
   prs_pkg::rsp_type          rsp_ff, rsp_in;

   // Memories and their registered read data
   logic [prs_pkg::CUM_W-1:0]  cum_mem  [MAX_PARTICLES];
   logic [prs_pkg::RAND_W-1:0] rand_mem [MAX_PARTICLES];
   logic [PART_W-1:0]          part_mem [MAX_PARTICLES];
   logic [prs_pkg::CUM_W-1:0]  cum_rd_ff;
   logic [prs_pkg::RAND_W-1:0] rand_rd_ff;
   logic [PART_W-1:0]          part_rd_ff;

   // Load-side signals
   logic                      req_acc;
   logic                      has_room;
   logic                      store;
   logic [IDX_W-1:0]          wr_addr;
   logic [prs_pkg::CUM_W-1:0] sum_add;
   logic [PART_W-1:0]         part_wdata;
   logic [CNT_W-1:0]          n_now;
   logic [prs_pkg::CUM_W-1:0] total_now;
   logic                      ovf_now;
   logic                      run_err;
   prs_pkg::status_type       err_now;

   // Search and emit signals
   logic                       multinomial;
   logic [IDX_W-1:0]           rand_addr;
   logic [prs_pkg::SLOT_W-1:0] slot_term;
   logic                       search_go;
   logic                       last_slot;
   logic                       out_free;
   logic                       load_rsp;
   logic signed [prs_pkg::ELEM_W-1:0] elem_wr [prs_pkg::NUM_ELEMS];
   logic signed [prs_pkg::ELEM_W-1:0] elem_rd [prs_pkg::NUM_ELEMS];

   assign req_stall = (state_ff != prs_pkg::S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign has_room  = (count_ff < CNT_W'(MAX_PARTICLES));
   assign store     = req_acc && has_room;
   assign wr_addr   = count_ff[IDX_W-1:0];
   assign sum_add   = sum_ff + prs_pkg::CUM_W'(req_data.weight);

   // Run summary as of the request with last set
   assign n_now     = has_room ? (count_ff + CNT_W'(1)) : count_ff;
   assign total_now = has_room ? sum_add : sum_ff;
   assign ovf_now   = ovf_ff || !has_room;

   always_comb begin
      priority if (ovf_now) begin
         err_now = prs_pkg::ST_OVERFLOW;
      end else if (method_ff == prs_pkg::M_RESIDUAL) begin
         err_now = prs_pkg::ST_NO_METHOD;
      end else if (total_now == '0) begin
         err_now = prs_pkg::ST_ZERO_WEIGHT;
      end else begin
         err_now = prs_pkg::ST_OK;
      end
   end
   assign run_err = (err_now != prs_pkg::ST_OK);

   // Pack the kept state elements, low ELEM_BITS bits each
   assign elem_wr[0] = req_data.elem_a;
   assign elem_wr[1] = req_data.elem_b;
   assign elem_wr[2] = req_data.elem_c;
   assign elem_wr[3] = req_data.elem_d;
   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         part_wdata[k*ELEM_BITS +: ELEM_BITS] = elem_wr[k][ELEM_BITS-1:0];
      end
   end

   // Unpack the selected particle, sign-extending; missing elements read 0
   always_comb begin
      logic signed [ELEM_BITS-1:0] part;
      part = '0;
      for (int k = 0; k < prs_pkg::NUM_ELEMS; k++) begin
         if (k < DIM) begin
            part       = part_rd_ff[k*ELEM_BITS +: ELEM_BITS];
            elem_rd[k] = prs_pkg::ELEM_W'(part);
         end else begin
            elem_rd[k] = '0;
         end
      end
   end

   // Search compare and slot bookkeeping
   assign multinomial = (method_ff == prs_pkg::M_MULTINOMIAL);
   assign slot_term   = multinomial ? prs_pkg::SLOT_W'(rand_rd_ff)
                      : ((prs_pkg::SLOT_W'(i_ff) << prs_pkg::RAND_W)
                         | prs_pkg::SLOT_W'(rand_rd_ff));
   assign search_go   = ((CNT_W+1)'(j_ff) + (CNT_W+1)'(1) < (CNT_W+1)'(n_ff))
                     && ({lhs_ff, {prs_pkg::RAND_W{1'b0}}}
                         < prs_pkg::CMP_W'(rhs_ff));
   assign last_slot   = ((CNT_W+1)'(i_ff) + (CNT_W+1)'(1) == (CNT_W+1)'(n_ff));
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prs_pkg::S_IDLE: begin
            if (req_acc && req_data.last) begin
               state_in = run_err ? prs_pkg::S_ERR : prs_pkg::S_START;
            end
         end
         prs_pkg::S_START: state_in = prs_pkg::S_RHS;
         prs_pkg::S_RHS:   state_in = prs_pkg::S_LHS;
         prs_pkg::S_LHS:   state_in = prs_pkg::S_CMP;
         prs_pkg::S_CMP: begin
            state_in = search_go ? prs_pkg::S_LHS : prs_pkg::S_OUT;
         end
         prs_pkg::S_OUT: begin
            if (out_free) begin
               state_in = last_slot ? prs_pkg::S_IDLE : prs_pkg::S_RHS;
            end
         end
         prs_pkg::S_ERR: begin
            if (out_free) begin
               state_in = prs_pkg::S_IDLE;
            end
         end
         default: state_in = prs_pkg::S_IDLE;
      endcase
   end

   // Datapath and result loading
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      sum_in   = sum_ff;
      n_in     = n_ff;
      total_in = total_ff;
      err_in   = err_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      rhs_in   = rhs_ff;
      lhs_in   = lhs_ff;
      load_rsp = 1'b0;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         prs_pkg::S_IDLE: begin
            if (req_acc) begin
               if (has_room) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in   = sum_add;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  sum_in   = '0;
                  n_in     = n_now;
                  total_in = total_now;
                  err_in   = err_now;
                  i_in     = '0;
                  j_in     = '0;
               end
            end
         end
         prs_pkg::S_START: begin
         end
         prs_pkg::S_RHS: begin
            rhs_in = prs_pkg::RHS_W'(slot_term) * prs_pkg::RHS_W'(total_ff);
            if (multinomial) begin
               j_in = '0;
            end
         end
         prs_pkg::S_LHS: begin
            if (multinomial) begin
               lhs_in = prs_pkg::LHS_W'(cum_rd_ff);
            end else begin
               lhs_in = prs_pkg::LHS_W'(cum_rd_ff) * prs_pkg::LHS_W'(n_ff);
            end
         end
         prs_pkg::S_CMP: begin
            if (search_go) begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         prs_pkg::S_OUT: begin
            if (out_free) begin
               load_rsp            = 1'b1;
               rsp_in.status       = prs_pkg::ST_OK;
               rsp_in.source_index = prs_pkg::INDEX_W'(j_ff);
               rsp_in.out_a        = elem_rd[0];
               rsp_in.out_b        = elem_rd[1];
               rsp_in.out_c        = elem_rd[2];
               rsp_in.out_d        = elem_rd[3];
               rsp_in.new_weight   = prs_pkg::NEW_WEIGHT_TABLE[6'(n_ff - CNT_W'(1))];
               rsp_in.final_res    = last_slot;
               if (!last_slot) begin
                  i_in = i_ff + IDX_W'(1);
               end
            end
         end
         prs_pkg::S_ERR: begin
            if (out_free) begin
               load_rsp            = 1'b1;
               rsp_in.status       = err_ff;
               rsp_in.source_index = '0;
               rsp_in.out_a        = '0;
               rsp_in.out_b        = '0;
               rsp_in.out_c        = '0;
               rsp_in.out_d        = '0;
               rsp_in.new_weight   = '0;
               rsp_in.final_res    = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   assign rand_addr    = (method_ff == prs_pkg::M_SYSTEMATIC) ? '0 : i_in;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prs_pkg::S_IDLE;
         method_ff    <= prs_pkg::M_SYSTEMATIC;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            method_ff <= prs_pkg::method_type'(csr_wr_data);
         end
      end
   end

   // Run, search and result registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      total_ff <= total_in;
      err_ff   <= err_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      rhs_ff   <= rhs_in;
      lhs_ff   <= lhs_in;
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   // Cumulative sum memory: written while loading, read at the search index
   always_ff @(posedge clock) begin
      if (store) begin
         cum_mem[wr_addr] <= sum_add;
      end
      cum_rd_ff <= cum_mem[j_in];
   end

   // Random fraction memory: read at the slot index, or at 0 in systematic mode
   always_ff @(posedge clock) begin
      if (store) begin
         rand_mem[wr_addr] <= req_data.rand_frac;
      end
      rand_rd_ff <= rand_mem[rand_addr];
   end

   // Particle state memory: read at the selected index
   always_ff @(posedge clock) begin
      if (store) begin
         part_mem[wr_addr] <= part_wdata;
      end
      part_rd_ff <= part_mem[j_in];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/prs_checker.sv =====
module prs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input prs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input prs_pkg::rsp_type rsp_data
);

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // The request that closes a run blocks further requests
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.last |=> req_stall)
      else $error("request accepted right after last");

   // Mid-run results only while the run is still busy
   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.final_res |-> req_stall)
      else $error("non-final result while idle");

   // Error results are single and carry no selection
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != prs_pkg::ST_OK
      |-> rsp_data.final_res && rsp_data.source_index == '0
          && rsp_data.new_weight == '0)
      else $error("malformed error result");

endmodule

bind particle_resampler prs_checker u_prs_checker (.*);

// ===== bench/testbench.sv =====
module testbench;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned RUN_ITEMS     = 260;   // directed plus random requests
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned END_CYCLES    = 20;

   // Weight patterns for one random run
   typedef enum int {
      W_RANDOM,
      W_ZERO,
      W_SPARSE,
      W_TINY,
      W_HEAVY
   } weight_mix_type;

   // Resampling predictor and result checker
   class resample_checker;
      logic [prs_pkg::CUM_W-1:0]  cum_sum [64];
      logic [prs_pkg::RAND_W-1:0] slot_rand [64];
      logic [prs_pkg::ELEM_W-1:0] particle_elem [64][prs_pkg::NUM_ELEMS];
      int unsigned                held;
      bit                         dropped;
      prs_pkg::method_type        method;
      prs_pkg::rsp_type           expected_slots[$];
      int unsigned                errors;
      int unsigned                checked;
      int unsigned                error_results;

      function new();
         held    = 0;
         dropped = 0;
         method  = prs_pkg::M_SYSTEMATIC;
         errors  = 0;
         checked = 0;
         error_results = 0;
      endfunction

      function void set_method(prs_pkg::method_type m);
         method = m;
      endfunction

      function int pending();
         return expected_slots.size();
      endfunction

      // keep the low ELEM_BITS bits, sign-extended
      function logic [prs_pkg::ELEM_W-1:0] trim_elem(logic [prs_pkg::ELEM_W-1:0] v);
         logic [prs_pkg::ELEM_W-1:0] mask;
         mask = {prs_pkg::ELEM_W{1'b1}} >> (prs_pkg::ELEM_W - prs_pkg::DEF_ELEM_BITS);
         v = v & mask;
         if (v[prs_pkg::DEF_ELEM_BITS-1]) v = v | ~mask;
         return v;
      endfunction

      function void push_error(prs_pkg::status_type code);
         prs_pkg::rsp_type e;
         e = '0;
         e.status    = code;
         e.final_res = 1'b1;
         expected_slots.push_back(e);
      endfunction

      // store one accepted particle; on last, queue the resampled slots
      function void note_particle(prs_pkg::req_type r);
         logic [prs_pkg::ELEM_W-1:0] raw [prs_pkg::NUM_ELEMS];
         logic [prs_pkg::CUM_W-1:0]  prev;
         logic [63:0]                total, rhs, lhs;
         logic [prs_pkg::RAND_W-1:0] rv;
         int unsigned                n, j;
         prs_pkg::rsp_type           e;
         raw = '{r.elem_a, r.elem_b, r.elem_c, r.elem_d};
         if (held < prs_pkg::DEF_MAX_PARTICLES) begin
            prev = '0;
            if (held != 0) prev = cum_sum[held-1];
            cum_sum[held]   = prev + r.weight;
            slot_rand[held] = r.rand_frac;
            for (int k = 0; k < prs_pkg::NUM_ELEMS; k++) begin
               particle_elem[held][k] = (k < prs_pkg::DEF_DIM) ? trim_elem(raw[k]) : '0;
            end
            held++;
         end else begin
            dropped = 1'b1;
         end
         if (!r.last) return;

         n    = held;
         held = 0;
         // overflow beats method, method beats zero weight
         if (dropped) begin
            dropped = 1'b0;
            push_error(prs_pkg::ST_OVERFLOW);
            return;
         end
         if (method == prs_pkg::M_RESIDUAL) begin
            push_error(prs_pkg::ST_NO_METHOD);
            return;
         end
         total = 64'(cum_sum[n-1]);
         if (total == 0) begin
            push_error(prs_pkg::ST_ZERO_WEIGHT);
            return;
         end

         j = 0;
         for (int unsigned i = 0; i < n; i++) begin
            rv = (method == prs_pkg::M_SYSTEMATIC) ? slot_rand[0] : slot_rand[i];
            if (method == prs_pkg::M_MULTINOMIAL) begin
               // fresh search: first cum*65536 >= r*total
               j   = 0;
               rhs = 64'(rv) * total;
               lhs = 64'(cum_sum[j]) << 16;
               while (j < n - 1 && lhs < rhs) begin
                  j++;
                  lhs = 64'(cum_sum[j]) << 16;
               end
            end else begin
               // forward-only search: cum*N*65536 >= (i*65536 + r)*total
               rhs = ((64'(i) << 16) + 64'(rv)) * total;
               lhs = (64'(cum_sum[j]) * n) << 16;
               while (j < n - 1 && lhs < rhs) begin
                  j++;
                  lhs = (64'(cum_sum[j]) * n) << 16;
               end
            end
            e.status       = prs_pkg::ST_OK;
            e.source_index = j[prs_pkg::INDEX_W-1:0];
            e.out_a        = particle_elem[j][0];
            e.out_b        = particle_elem[j][1];
            e.out_c        = particle_elem[j][2];
            e.out_d        = particle_elem[j][3];
            e.new_weight   = prs_pkg::NEW_W_W'(65536 / n);
            e.final_res    = (i == n - 1);
            expected_slots.push_back(e);
         end
      endfunction

      function void field_check(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_slot(prs_pkg::rsp_type got);
         prs_pkg::rsp_type want;
         if (expected_slots.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = expected_slots.pop_front();
         checked++;
         if (want.status != prs_pkg::ST_OK) error_results++;
         field_check("status", want.status, got.status);
         field_check("source_index", want.source_index, got.source_index);
         field_check("out_a", want.out_a, got.out_a);
         field_check("out_b", want.out_b, got.out_b);
         field_check("out_c", want.out_c, got.out_c);
         field_check("out_d", want.out_d, got.out_d);
         field_check("new_weight", want.new_weight, got.new_weight);
         field_check("final_res", want.final_res, got.final_res);
      endfunction
   endclass

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   prs_pkg::req_type req_data    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   prs_pkg::rsp_type rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [1:0]       csr_wr_data = '0;

   resample_checker book = new();
   bit              quiet = 1'b0;     // no idling on either side while set
   int unsigned     sent = 0;
   int unsigned     runs = 0;
   int unsigned     cycle_count = 0;

   particle_resampler dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("particle_resampler test failed");
         $finish;
      end
   end

   // result side: random stall before each result, then take it
   initial begin
      int unsigned hold;
      wait (!reset);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         book.check_slot(rsp_data);
      end
   end

   function automatic prs_pkg::req_type make_req(logic [15:0] w, logic [15:0] rf,
                                                 logic [15:0] a, logic [15:0] b,
                                                 logic [15:0] c, logic [15:0] d,
                                                 logic last);
      prs_pkg::req_type r;
      r.weight    = w;
      r.rand_frac = rf;
      r.elem_a    = a;
      r.elem_b    = b;
      r.elem_c    = c;
      r.elem_d    = d;
      r.last      = last;
      return r;
   endfunction

   function automatic logic [15:0] pick_weight(weight_mix_type mix);
      case (mix)
         W_ZERO:   return '0;
         W_SPARSE: return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'h0;
         W_TINY:   return 16'($urandom_range(0, 3));
         W_HEAVY:  return 16'($urandom_range(65000, 65535));
         default:  return 16'($urandom);
      endcase
   endfunction

   // present one request and hold it until taken; valid stays high if no gap follows
   task automatic send_request(prs_pkg::req_type r);
      int unsigned gap;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      book.note_particle(r);
      sent++;
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drop valid, wait out all expected results and then the extra settle time
   task automatic settle(int unsigned extra);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_method(prs_pkg::method_type m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      book.set_method(m);
   endtask

   task automatic send_run(int unsigned count, weight_mix_type mix);
      for (int unsigned k = 0; k < count; k++) begin
         send_request(make_req(pick_weight(mix), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 16'($urandom),
                               k == count - 1));
      end
      runs++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_method(prs_pkg::M_SYSTEMATIC);

      // single particle with extreme fields
      send_request(make_req(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 1));
      // systematic over four particles, zero-weight lead
      send_request(make_req(16'h0000, 16'h0000, 16'h0001, 16'hFFFE, 16'h1234, 16'hEDCB, 0));
      send_request(make_req(16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 0));
      send_request(make_req(16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 0));
      send_request(make_req(16'h8000, 16'h0001, 16'hAAAA, 16'h5555, 16'hFF00, 16'h00FF, 1));
      // zero total weight
      send_request(make_req(16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 16'h0004, 0));
      send_request(make_req(16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0));
      send_request(make_req(16'h0000, 16'h1234, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1));
      runs += 3;

      // stratified
      settle(SETTLE_CYCLES);
      write_method(prs_pkg::M_STRATIFIED);
      send_request(make_req(16'h4000, 16'hFFFF, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 0));
      send_request(make_req(16'h0000, 16'h0000, 16'hFFF0, 16'hFFE0, 16'hFFD0, 16'hFFC0, 0));
      send_request(make_req(16'hC000, 16'h5555, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 0));
      send_request(make_req(16'h0001, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1));

      // multinomial
      settle(SETTLE_CYCLES);
      write_method(prs_pkg::M_MULTINOMIAL);
      send_request(make_req(16'h0001, 16'h0000, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 0));
      send_request(make_req(16'hFFFF, 16'hFFFF, 16'h5555, 16'h6666, 16'h7777, 16'h8888, 0));
      send_request(make_req(16'h0000, 16'h8000, 16'h9999, 16'hAAAA, 16'hBBBB, 16'hCCCC, 0));
      send_request(make_req(16'h7FFF, 16'h0001, 16'hDDDD, 16'hEEEE, 16'hFFFF, 16'h0000, 1));

      // residual reports not implemented, also over zero weight
      settle(SETTLE_CYCLES);
      write_method(prs_pkg::M_RESIDUAL);
      send_request(make_req(16'h1000, 16'h2000, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 0));
      send_request(make_req(16'h3000, 16'h4000, 16'h0002, 16'h0002, 16'h0002, 16'h0002, 1));
      send_request(make_req(16'h0000, 16'h0000, 16'h0003, 16'h0003, 16'h0003, 16'h0003, 1));
      runs += 4;

      // random runs; one full run and one overflow run along the way
      while (sent < RUN_ITEMS) begin
         quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) begin
            settle(SETTLE_CYCLES);
            write_method(prs_pkg::method_type'($urandom_range(0, 3)));
         end
         if (runs == 12)
            send_run(prs_pkg::DEF_MAX_PARTICLES,
                     ($urandom_range(0, 1) == 0) ? W_SPARSE : W_RANDOM);
         else if (runs == 20)
            send_run(prs_pkg::DEF_MAX_PARTICLES + 1 + $urandom_range(0, 2),
                     weight_mix_type'($urandom_range(0, 4)));
         else
            send_run($urandom_range(1, 8), weight_mix_type'($urandom_range(0, 4)));
      end

      settle(END_CYCLES);
      $display("%0d requests in %0d runs, %0d results checked (%0d error results)",
               sent, runs, book.checked, book.error_results);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("particle_resampler test passed");
      end else begin
         $display("particle_resampler test failed");
      end
      $finish;
   end

endmodule
